// ----- design/mmf_pkg.sv -----
`timescale 1ns / 1ps
package mmf_pkg;

  localparam int unsigned TagDepthDef = 8;
  localparam int unsigned WsHoldDef   = 32;
  localparam int unsigned QDepth      = 4;

  // result kinds
  localparam logic [2:0] KIND_BYTE  = 3'd0;
  localparam logic [2:0] KIND_ANCHOR = 3'd1;
  localparam logic [2:0] KIND_SEP   = 3'd2;
  localparam logic [2:0] KIND_TERM  = 3'd3;
  localparam logic [2:0] KIND_BREAK = 3'd4;
  localparam logic [2:0] KIND_END   = 3'd5;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_TAG  = 2'd1;
  localparam logic [1:0] ERR_HOLD = 2'd2;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChNl    = 8'h0a;

  // byte class as seen in normal mode
  typedef enum logic [3:0] {
    CL_OTHER, CL_CARET, CL_TILDE, CL_BSLASH, CL_LT, CL_GT, CL_BAR, CL_PRINT, CL_LEAD
  } cls_e;

  // tag letter class
  typedef enum logic [1:0] {TK_NONE, TK_RUBY, TK_PLAIN, TK_SKIP} tk_e;

  // escape class
  typedef enum logic [1:0] {EK_NONE, EK_BREAK, EK_NL, EK_SELF} ek_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
    cls_e       cls;
    tk_e        tag;
    ek_e        esc;
    logic       is_digit;
    logic       is_colon;
    logic       is_cont;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       fin;
    logic [1:0] err;
  } res_t;

  // continuation bytes that follow a utf-8 lead
  function automatic logic [1:0] utf8_extra(input logic [7:0] lead);
    logic [1:0] r;
    if (lead <= 8'hdf) r = 2'd1;
    else if (lead <= 8'hef) r = 2'd2;
    else r = 2'd3;
    return r;
  endfunction

endpackage

// ----- design/mmf_front.sv -----
`timescale 1ns / 1ps
module mmf_front (
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // text_byte
  input  logic             s_axis_tlast,  // end_of_message
  output logic             wr_valid_o,
  input  logic             wr_ready_i,
  output mmf_pkg::item_t   wr_item_o
);

  logic [7:0] b;
  logic       lc_r, lc_a, lc_skip;

  assign b = s_axis_tdata;
  assign wr_valid_o = s_axis_tvalid;
  assign s_axis_tready = wr_ready_i;

  // letter tests, either case
  always_comb begin
    lc_r    = (b == 8'h72) || (b == 8'h52);
    lc_a    = (b == 8'h61) || (b == 8'h41);
    lc_skip = (b == 8'h64) || (b == 8'h44) || (b == 8'h63) || (b == 8'h43) ||
              (b == 8'h66) || (b == 8'h46) || (b == 8'h73) || (b == 8'h53) ||
              (b == 8'h77) || (b == 8'h57);
  end

  // classify the word
  always_comb begin
    wr_item_o.data     = b;
    wr_item_o.eom      = s_axis_tlast;
    wr_item_o.is_digit = (b >= 8'h30) && (b <= 8'h39);
    wr_item_o.is_colon = (b == 8'h3a);
    wr_item_o.is_cont  = (b >= 8'h80) && (b <= 8'hbf);

    if (b == 8'h5e) wr_item_o.cls = mmf_pkg::CL_CARET;
    else if (b == 8'h7e) wr_item_o.cls = mmf_pkg::CL_TILDE;
    else if (b == 8'h5c) wr_item_o.cls = mmf_pkg::CL_BSLASH;
    else if (b == 8'h3c) wr_item_o.cls = mmf_pkg::CL_LT;
    else if (b == 8'h3e) wr_item_o.cls = mmf_pkg::CL_GT;
    else if (b == 8'h7c) wr_item_o.cls = mmf_pkg::CL_BAR;
    else if (b == mmf_pkg::ChNl || (b >= 8'h20 && b <= 8'h7e)) wr_item_o.cls = mmf_pkg::CL_PRINT;
    else if (b >= 8'hc2 && b <= 8'hf4) wr_item_o.cls = mmf_pkg::CL_LEAD;
    else wr_item_o.cls = mmf_pkg::CL_OTHER;

    if (lc_r) wr_item_o.tag = mmf_pkg::TK_RUBY;
    else if (lc_a) wr_item_o.tag = mmf_pkg::TK_PLAIN;
    else if (lc_skip) wr_item_o.tag = mmf_pkg::TK_SKIP;
    else wr_item_o.tag = mmf_pkg::TK_NONE;

    if (b == 8'h6b) wr_item_o.esc = mmf_pkg::EK_BREAK;
    else if (b == 8'h6e) wr_item_o.esc = mmf_pkg::EK_NL;
    else if (b == 8'h5e || b == 8'h7e || b == 8'h3c || b == 8'h3e ||
             b == 8'h7c || b == 8'h5c) wr_item_o.esc = mmf_pkg::EK_SELF;
    else wr_item_o.esc = mmf_pkg::EK_NONE;
  end

endmodule

// ----- design/mmf_queue.sv -----
`timescale 1ns / 1ps
module mmf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  mmf_pkg::item_t wr_item_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output mmf_pkg::item_t rd_item_o
);

  localparam int unsigned AW = $clog2(mmf_pkg::QDepth);

  mmf_pkg::item_t slots_q [mmf_pkg::QDepth];
  logic [AW-1:0]  wp_q, rp_q;
  logic [AW:0]    cnt_q;
  logic           push, pop;

  assign wr_ready_o = (cnt_q != (AW+1)'(mmf_pkg::QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = slots_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) slots_q[wp_q] <= wr_item_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + AW'(1);
      if (pop) rp_q <= rp_q + AW'(1);
      if (push && !pop) cnt_q <= cnt_q + (AW+1)'(1);
      else if (pop && !push) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

endmodule

// ----- design/mmf_back.sv -----
`timescale 1ns / 1ps
module mmf_back #(
  parameter int unsigned TAG_DEPTH = mmf_pkg::TagDepthDef,
  parameter int unsigned WS_HOLD   = mmf_pkg::WsHoldDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rd_valid_i,
  output logic           rd_ready_o,
  input  mmf_pkg::item_t rd_item_i,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output mmf_pkg::res_t  res_o
);

  localparam int unsigned TW  = $clog2(TAG_DEPTH + 1);
  localparam int unsigned SAW = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
  localparam int unsigned HW  = $clog2(WS_HOLD + 1);
  localparam int unsigned AW  = (WS_HOLD > 1) ? $clog2(WS_HOLD) : 1;

  typedef enum logic [5:0] {
    PM_NORMAL = 6'b000001,
    PM_ESC    = 6'b000010,
    PM_TAG    = 6'b000100,
    PM_DIGITS = 6'b001000,
    PM_READ   = 6'b010000,
    PM_UTF8   = 6'b100000
  } pm_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EMIT  = 3'b010,
    ST_CLOSE = 3'b100
  } st_e;

  st_e                state_q, state_d;
  pm_e                mode_q, mode_d;
  logic [TAG_DEPTH-1:0] stk_q, stk_d;
  logic [TW-1:0]      tcnt_q, tcnt_d;
  logic               rs_q, rs_d;
  logic [1:0]         upend_q, upend_d;
  logic [7:0]         ub_q [3];
  logic [7:0]         ub_d [3];
  logic [HW-1:0]      held_q, held_d;
  logic               brk_q, brk_d;
  logic               seg_q, seg_d;
  logic               open_q, open_d;
  logic [HW-1:0]      flush_q, flush_d;
  mmf_pkg::res_t      body_q [4];
  mmf_pkg::res_t      body_d [4];
  logic [2:0]         bn_q, bn_d, bi_q, bi_d;
  logic               eom_q, eom_d;
  logic               endph_q, endph_d;
  mmf_pkg::res_t      out_q;
  logic               ov_q;

  logic               ws_mem [WS_HOLD];
  logic               ws_rd_q;
  logic               ws_we, ws_wd;
  logic [AW-1:0]      ws_wa;

  logic               can_emit, em_valid;
  mmf_pkg::res_t      em_res;

  logic               do_norm, do_eb, do_push, push_ruby, top_ruby;
  logic [7:0]         eb_v;
  logic [2:0]         total, uidx;
  logic [SAW-1:0]     top_idx;

  assign can_emit = !ov_q || m_axis_tready;
  assign m_axis_tvalid = ov_q;
  assign res_o = out_q;
  assign top_idx = SAW'(tcnt_q - TW'(1));
  assign top_ruby = (tcnt_q != '0) && stk_q[top_idx];
  assign total = {1'b0, mmf_pkg::utf8_extra(ub_q[0])} + 3'd1;
  assign uidx = total - {1'b0, upend_q};

  function automatic mmf_pkg::res_t mk(input logic [2:0] k, input logic [7:0] d,
                                       input logic f, input logic [1:0] e);
    mmf_pkg::res_t r;
    r.kind = k;
    r.data = d;
    r.fin  = f;
    r.err  = e;
    return r;
  endfunction

  // decode and sequencing
  always_comb begin
    state_d = state_q;
    mode_d = mode_q;
    stk_d = stk_q;
    tcnt_d = tcnt_q;
    rs_d = rs_q;
    upend_d = upend_q;
    ub_d = ub_q;
    held_d = held_q;
    brk_d = brk_q;
    seg_d = seg_q;
    open_d = open_q;
    flush_d = flush_q;
    body_d = body_q;
    bn_d = bn_q;
    bi_d = bi_q;
    eom_d = eom_q;
    endph_d = endph_q;
    rd_ready_o = 1'b0;
    em_valid = 1'b0;
    em_res = mk(mmf_pkg::KIND_BYTE, 8'h00, 1'b0, mmf_pkg::ERR_NONE);
    ws_we = 1'b0;
    ws_wd = 1'b0;
    ws_wa = AW'(held_q);
    do_norm = 1'b0;
    do_eb = 1'b0;
    do_push = 1'b0;
    push_ruby = 1'b0;
    eb_v = rd_item_i.data;

    case (state_q)
      ST_IDLE: begin
        rd_ready_o = 1'b1;
        if (rd_valid_i) begin
          bn_d = '0;
          bi_d = '0;
          open_d = 1'b0;
          flush_d = '0;
          eom_d = rd_item_i.eom;
          state_d = ST_EMIT;
          case (mode_q)
            PM_ESC: begin
              mode_d = PM_NORMAL;
              case (rd_item_i.esc)
                mmf_pkg::EK_BREAK: begin
                  if (brk_q) begin
                    body_d[0] = mk(mmf_pkg::KIND_BREAK, 8'h00, 1'b0, mmf_pkg::ERR_NONE);
                    bn_d = 3'd1;
                  end
                  held_d = '0;
                  brk_d = 1'b1;
                  seg_d = 1'b0;
                end
                mmf_pkg::EK_NL: begin
                  do_eb = 1'b1;
                  eb_v = mmf_pkg::ChNl;
                end
                mmf_pkg::EK_SELF: do_eb = 1'b1;
                default: ;
              endcase
            end
            PM_TAG: begin
              mode_d = PM_NORMAL;
              if (rd_item_i.tag != mmf_pkg::TK_NONE) begin
                do_push = 1'b1;
                push_ruby = (rd_item_i.tag == mmf_pkg::TK_RUBY);
                if (rd_item_i.tag == mmf_pkg::TK_SKIP) mode_d = PM_DIGITS;
              end
            end
            PM_DIGITS: begin
              if (rd_item_i.is_digit) begin
              end else if (rd_item_i.is_colon) begin
                mode_d = PM_NORMAL;
              end else begin
                do_norm = 1'b1;
              end
            end
            PM_READ: begin
              if (rd_item_i.cls == mmf_pkg::CL_GT) do_norm = 1'b1;
              else do_eb = 1'b1;
            end
            PM_UTF8: begin
              if (rd_item_i.is_cont && upend_q != 2'd0) begin
                upend_d = upend_q - 2'd1;
                if (upend_q == 2'd1) begin
                  // sequence complete
                  for (int i = 0; i < 4; i++) begin
                    if (3'(i) < total - 3'd1)
                      body_d[i] = mk(mmf_pkg::KIND_BYTE, ub_q[(i < 3) ? i : 0], 1'b0,
                                     mmf_pkg::ERR_NONE);
                    else if (3'(i) == total - 3'd1)
                      body_d[i] = mk(mmf_pkg::KIND_BYTE, rd_item_i.data, 1'b0,
                                     mmf_pkg::ERR_NONE);
                  end
                  bn_d = total;
                  open_d = 1'b1;
                  mode_d = PM_NORMAL;
                end else begin
                  ub_d[uidx[1:0]] = rd_item_i.data;
                end
              end else begin
                upend_d = 2'd0;
                do_norm = 1'b1;
              end
            end
            default: do_norm = 1'b1;
          endcase

          // normal-mode handling
          if (do_norm) begin
            mode_d = PM_NORMAL;
            case (rd_item_i.cls)
              mmf_pkg::CL_CARET: begin
                do_eb = 1'b1;
                eb_v = mmf_pkg::ChSpace;
              end
              mmf_pkg::CL_TILDE: begin
                do_eb = 1'b1;
                eb_v = mmf_pkg::ChComma;
              end
              mmf_pkg::CL_BSLASH: mode_d = PM_ESC;
              mmf_pkg::CL_LT: mode_d = PM_TAG;
              mmf_pkg::CL_BAR: begin
                if (top_ruby && !rs_q) begin
                  body_d[0] = mk(mmf_pkg::KIND_SEP, 8'h00, 1'b0, mmf_pkg::ERR_NONE);
                  bn_d = 3'd1;
                  open_d = 1'b1;
                  rs_d = 1'b1;
                  mode_d = PM_READ;
                end
              end
              mmf_pkg::CL_GT: begin
                if (tcnt_q != '0) begin
                  if (top_ruby) begin
                    open_d = 1'b1;
                    if (!rs_q) begin
                      body_d[0] = mk(mmf_pkg::KIND_SEP, 8'h00, 1'b0, mmf_pkg::ERR_NONE);
                      body_d[1] = mk(mmf_pkg::KIND_TERM, 8'h00, 1'b0, mmf_pkg::ERR_NONE);
                      bn_d = 3'd2;
                    end else begin
                      body_d[0] = mk(mmf_pkg::KIND_TERM, 8'h00, 1'b0, mmf_pkg::ERR_NONE);
                      bn_d = 3'd1;
                    end
                  end
                  tcnt_d = tcnt_q - TW'(1);
                end
              end
              mmf_pkg::CL_PRINT: do_eb = 1'b1;
              mmf_pkg::CL_LEAD: begin
                ub_d[0] = rd_item_i.data;
                upend_d = mmf_pkg::utf8_extra(rd_item_i.data);
                mode_d = PM_UTF8;
              end
              default: ;
            endcase
          end

          // tag push
          if (do_push) begin
            if (tcnt_q >= TW'(TAG_DEPTH)) begin
              body_d[0] = mk(mmf_pkg::KIND_BYTE, 8'h00, 1'b0, mmf_pkg::ERR_TAG);
              bn_d = 3'd1;
            end else begin
              stk_d[SAW'(tcnt_q)] = push_ruby;
              tcnt_d = tcnt_q + TW'(1);
              if (push_ruby) begin
                rs_d = 1'b0;
                body_d[0] = mk(mmf_pkg::KIND_ANCHOR, 8'h00, 1'b0, mmf_pkg::ERR_NONE);
                bn_d = 3'd1;
                open_d = 1'b1;
              end
            end
          end

          // visible byte, with leading whitespace held back
          if (do_eb) begin
            if (!seg_q && (eb_v == mmf_pkg::ChSpace || eb_v == mmf_pkg::ChTab)) begin
              if (held_q >= HW'(WS_HOLD)) begin
                body_d[0] = mk(mmf_pkg::KIND_BYTE, 8'h00, 1'b0, mmf_pkg::ERR_HOLD);
                bn_d = 3'd1;
              end else begin
                ws_we = 1'b1;
                ws_wd = (eb_v == mmf_pkg::ChTab);
                held_d = held_q + HW'(1);
              end
            end else begin
              body_d[0] = mk(mmf_pkg::KIND_BYTE, eb_v, 1'b0, mmf_pkg::ERR_NONE);
              bn_d = 3'd1;
              open_d = 1'b1;
            end
          end
        end
      end

      ST_EMIT: begin
        if (can_emit) begin
          if (open_q && brk_q) begin
            em_valid = 1'b1;
            em_res = mk(mmf_pkg::KIND_BREAK, 8'h00, 1'b0, mmf_pkg::ERR_NONE);
            brk_d = 1'b0;
          end else if (open_q && flush_q < held_q) begin
            em_valid = 1'b1;
            em_res = mk(mmf_pkg::KIND_BYTE, ws_rd_q ? mmf_pkg::ChTab : mmf_pkg::ChSpace,
                        1'b0, mmf_pkg::ERR_NONE);
            flush_d = flush_q + HW'(1);
          end else begin
            if (open_q) begin
              open_d = 1'b0;
              held_d = '0;
              seg_d = 1'b1;
              flush_d = '0;
            end
            if (bi_q < bn_q) begin
              em_valid = 1'b1;
              em_res = body_q[bi_q[1:0]];
              bi_d = bi_q + 3'd1;
            end else if (endph_q) begin
              // message closed, back to reset state
              mode_d = PM_NORMAL;
              tcnt_d = '0;
              rs_d = 1'b0;
              upend_d = 2'd0;
              held_d = '0;
              brk_d = 1'b0;
              seg_d = 1'b0;
              eom_d = 1'b0;
              endph_d = 1'b0;
              state_d = ST_IDLE;
            end else if (eom_q) begin
              state_d = ST_CLOSE;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end

      ST_CLOSE: begin
        bi_d = '0;
        flush_d = '0;
        if (tcnt_q != '0) begin
          // close open tags from the top down
          tcnt_d = tcnt_q - TW'(1);
          if (stk_q[top_idx]) begin
            rs_d = 1'b1;
            open_d = 1'b1;
            state_d = ST_EMIT;
            if (!rs_q) begin
              body_d[0] = mk(mmf_pkg::KIND_SEP, 8'h00, 1'b0, mmf_pkg::ERR_NONE);
              body_d[1] = mk(mmf_pkg::KIND_TERM, 8'h00, 1'b0, mmf_pkg::ERR_NONE);
              bn_d = 3'd2;
            end else begin
              body_d[0] = mk(mmf_pkg::KIND_TERM, 8'h00, 1'b0, mmf_pkg::ERR_NONE);
              bn_d = 3'd1;
            end
          end
        end else begin
          body_d[0] = mk(mmf_pkg::KIND_END, 8'h00, 1'b1, mmf_pkg::ERR_NONE);
          bn_d = 3'd1;
          open_d = (held_q != '0);
          endph_d = 1'b1;
          state_d = ST_EMIT;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // whitespace hold buffer
  always_ff @(posedge clk_i) begin
    if (ws_we) ws_mem[ws_wa] <= ws_wd;
    ws_rd_q <= ws_mem[AW'(flush_d)];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    stk_q <= stk_d;
    ub_q <= ub_d;
    body_q <= body_d;
    if (em_valid) out_q <= em_res;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q <= PM_NORMAL;
      tcnt_q <= '0;
      rs_q <= 1'b0;
      upend_q <= 2'd0;
      held_q <= '0;
      brk_q <= 1'b0;
      seg_q <= 1'b0;
      open_q <= 1'b0;
      flush_q <= '0;
      bn_q <= '0;
      bi_q <= '0;
      eom_q <= 1'b0;
      endph_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q <= mode_d;
      tcnt_q <= tcnt_d;
      rs_q <= rs_d;
      upend_q <= upend_d;
      held_q <= held_d;
      brk_q <= brk_d;
      seg_q <= seg_d;
      open_q <= open_d;
      flush_q <= flush_d;
      bn_q <= bn_d;
      bi_q <= bi_d;
      eom_q <= eom_d;
      endph_q <= endph_d;
      ov_q <= em_valid || (ov_q && !m_axis_tready);
    end
  end

endmodule

// ----- design/message_markup_filter.sv -----
`timescale 1ns / 1ps
// Message markup filter.
// Input channel s_axis: one message byte per word, tlast on the last byte
// of a message. Output channel m_axis: one result per word; tuser holds the
// kind (byte, ruby anchor, separator, terminator, segment break, message
// end), tdata the visible byte and the error code, tlast the message end.
// A front stage classifies each byte and pushes it into a four-entry queue;
// the back stage decodes one byte at a time and sends its results one per
// cycle, while the receiver is ready, through an output register.
// A plain byte passes the back stage's decode, send and finish steps, and
// the back stage takes no new byte from the queue until it has finished
// the last one. Bytes that open a segment first send a pending break and
// then each held space or tab; at message end the sequencer closes each
// open tag, sending the results of ruby tags, then sends the message end.
// Reset clears the parser to normal mode with no tags, no held whitespace
// and an empty queue. When the receiver stalls, the output register holds
// its word, the back stage waits, and input is taken until the queue fills.
module message_markup_filter #(
  parameter int unsigned TAG_DEPTH = mmf_pkg::TagDepthDef,
  parameter int unsigned WS_HOLD   = mmf_pkg::WsHoldDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte[7:0]
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_byte[7:0], error_code[9:8], zero
  output logic [2:0]  m_axis_tuser,   // kind[2:0]
  output logic        m_axis_tlast    // final_item
);

  logic           wr_valid, wr_ready, rd_valid, rd_ready;
  mmf_pkg::item_t wr_item, rd_item;
  mmf_pkg::res_t  res;

  mmf_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .wr_valid_o    (wr_valid),
    .wr_ready_i    (wr_ready),
    .wr_item_o     (wr_item)
  );

  mmf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_ready_o (wr_ready),
    .wr_item_i  (wr_item),
    .rd_valid_o (rd_valid),
    .rd_ready_i (rd_ready),
    .rd_item_o  (rd_item)
  );

  mmf_back #(
    .TAG_DEPTH (TAG_DEPTH),
    .WS_HOLD   (WS_HOLD)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_valid_i    (rd_valid),
    .rd_ready_o    (rd_ready),
    .rd_item_i     (rd_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .res_o         (res)
  );

  // result packing
  assign m_axis_tdata = {6'd0, res.err, res.data};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.fin;

endmodule

// ----- tb/tb_message_markup_filter.sv -----
`timescale 1ns / 1ps
module tb_message_markup_filter;

  localparam int TagDepth = 8;
  localparam int WsHold   = 32;
  localparam int StallLimit = 20000;

  // parser modes of the predictor
  typedef enum logic [2:0] {
    PM_NORMAL, PM_ESC, PM_TAG, PM_DIGITS, PM_READING, PM_UTF8
  } pmode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
  } word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  message_markup_filter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  word_t         pending_words[$];
  mmf_pkg::res_t expected_results[$];
  int    errors;
  int    send_idle_pct;
  int    recv_idle_pct;
  bit    hold_send;
  bit    stim_done;
  int    quiet_cycles;

  // predictor state
  pmode_e     p_mode;
  logic       p_tags[TagDepth];
  int         p_tag_cnt;
  logic       p_read_seen;
  int         p_utf_pend;
  logic [7:0] p_utf[4];
  logic       p_held_tab[WsHold];
  int         p_held_cnt;
  logic       p_brk;
  logic       p_content;

  function automatic void put_result(logic [2:0] k, logic [7:0] d, logic f, logic [1:0] e);
    mmf_pkg::res_t r;
    r.kind = k;
    r.data = d;
    r.fin = f;
    r.err = e;
    expected_results = {expected_results, r};
  endfunction

  function automatic void open_segment();
    if (p_brk) begin
      put_result(mmf_pkg::KIND_BREAK, 8'h00, 1'b0, mmf_pkg::ERR_NONE);
      p_brk = 1'b0;
    end
    for (int i = 0; i < p_held_cnt; i++)
      put_result(mmf_pkg::KIND_BYTE, p_held_tab[i] ? mmf_pkg::ChTab : mmf_pkg::ChSpace,
                 1'b0, mmf_pkg::ERR_NONE);
    p_held_cnt = 0;
    p_content = 1'b1;
  endfunction

  function automatic void visible_byte(logic [7:0] b);
    if (!p_content && (b == mmf_pkg::ChSpace || b == mmf_pkg::ChTab)) begin
      if (p_held_cnt >= WsHold)
        put_result(mmf_pkg::KIND_BYTE, 8'h00, 1'b0, mmf_pkg::ERR_HOLD);
      else begin
        p_held_tab[p_held_cnt] = (b == mmf_pkg::ChTab);
        p_held_cnt++;
      end
    end else begin
      open_segment();
      put_result(mmf_pkg::KIND_BYTE, b, 1'b0, mmf_pkg::ERR_NONE);
    end
  endfunction

  function automatic void marker(logic [2:0] k);
    open_segment();
    put_result(k, 8'h00, 1'b0, mmf_pkg::ERR_NONE);
  endfunction

  function automatic bit push_tag(logic ruby);
    if (p_tag_cnt >= TagDepth) begin
      put_result(mmf_pkg::KIND_BYTE, 8'h00, 1'b0, mmf_pkg::ERR_TAG);
      return 1'b0;
    end
    p_tags[p_tag_cnt] = ruby;
    p_tag_cnt++;
    return 1'b1;
  endfunction

  function automatic int cont_count(logic [7:0] lead);
    return lead <= 8'hdf ? 1 : (lead <= 8'hef ? 2 : 3);
  endfunction

  function automatic bit is_letter(logic [7:0] c, logic [7:0] lower);
    return c == lower || c == lower - 8'd32;
  endfunction

  function automatic void plain_byte(logic [7:0] b);
    p_mode = PM_NORMAL;
    if (b == "^") visible_byte(mmf_pkg::ChSpace);
    else if (b == "~") visible_byte(mmf_pkg::ChComma);
    else if (b == "\\") p_mode = PM_ESC;
    else if (b == "<") p_mode = PM_TAG;
    else if (b == "|") begin
      if (p_tag_cnt > 0 && p_tags[p_tag_cnt-1] && !p_read_seen) begin
        marker(mmf_pkg::KIND_SEP);
        p_read_seen = 1'b1;
        p_mode = PM_READING;
      end
    end else if (b == ">") begin
      if (p_tag_cnt > 0) begin
        if (p_tags[p_tag_cnt-1]) begin
          if (!p_read_seen) marker(mmf_pkg::KIND_SEP);
          marker(mmf_pkg::KIND_TERM);
        end
        p_tag_cnt--;
      end
    end else if (b == mmf_pkg::ChNl || (b >= 8'h20 && b <= 8'h7e)) visible_byte(b);
    else if (b >= 8'hc2 && b <= 8'hf4) begin
      p_utf[0] = b;
      p_utf_pend = cont_count(b);
      p_mode = PM_UTF8;
    end
  endfunction

  function automatic void predict_word(word_t w);
    logic [7:0] b;
    int total;
    b = w.data;
    case (p_mode)
      PM_ESC: begin
        p_mode = PM_NORMAL;
        if (b == "k") begin
          if (p_brk) put_result(mmf_pkg::KIND_BREAK, 8'h00, 1'b0, mmf_pkg::ERR_NONE);
          p_held_cnt = 0;
          p_brk = 1'b1;
          p_content = 1'b0;
        end else if (b == "n") visible_byte(mmf_pkg::ChNl);
        else if (b == "^" || b == "~" || b == "<" || b == ">" || b == "|" || b == "\\")
          visible_byte(b);
      end
      PM_TAG: begin
        p_mode = PM_NORMAL;
        if (is_letter(b, "r")) begin
          if (push_tag(1'b1)) begin
            p_read_seen = 1'b0;
            marker(mmf_pkg::KIND_ANCHOR);
          end
        end else if (is_letter(b, "a")) void'(push_tag(1'b0));
        else if (is_letter(b, "d") || is_letter(b, "c") || is_letter(b, "f") ||
                 is_letter(b, "s") || is_letter(b, "w")) begin
          void'(push_tag(1'b0));
          p_mode = PM_DIGITS;
        end
      end
      PM_DIGITS: begin
        if (!(b >= "0" && b <= "9")) begin
          if (b == ":") p_mode = PM_NORMAL;
          else plain_byte(b);
        end
      end
      PM_READING: begin
        if (b == ">") plain_byte(b);
        else visible_byte(b);
      end
      PM_UTF8: begin
        if (b >= 8'h80 && b <= 8'hbf && p_utf_pend > 0) begin
          total = cont_count(p_utf[0]) + 1;
          p_utf[(total - p_utf_pend) & 3] = b;
          p_utf_pend--;
          if (p_utf_pend == 0) begin
            for (int i = 0; i < total; i++) visible_byte(p_utf[i]);
            p_mode = PM_NORMAL;
          end
        end else begin
          p_utf_pend = 0;
          plain_byte(b);
        end
      end
      default: plain_byte(b);
    endcase
    // message end closes ruby tags, flushes held whitespace and expects the end result
    if (w.eom) begin
      for (int i = p_tag_cnt; i > 0; i--) begin
        if (p_tags[i-1]) begin
          if (!p_read_seen) marker(mmf_pkg::KIND_SEP);
          marker(mmf_pkg::KIND_TERM);
          p_read_seen = 1'b1;
        end
      end
      if (p_held_cnt > 0) open_segment();
      put_result(mmf_pkg::KIND_END, 8'h00, 1'b1, mmf_pkg::ERR_NONE);
      p_mode = PM_NORMAL;
      p_tag_cnt = 0;
      p_read_seen = 1'b0;
      p_utf_pend = 0;
      p_held_cnt = 0;
      p_brk = 1'b0;
      p_content = 1'b0;
    end
  endfunction

  // stimulus helpers
  task automatic add_byte(logic [7:0] b, logic eom = 1'b0);
    word_t w;
    w.data = b;
    w.eom = eom;
    pending_words = {pending_words, w};
  endtask

  task automatic add_text(string s, logic eom_at_end = 1'b1);
    for (int i = 0; i < s.len(); i++)
      add_byte(s[i], eom_at_end && i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // one random token, mostly well-formed markup
  task automatic add_token();
    int sel;
    logic [7:0] lead;
    sel = $urandom_range(99);
    if (sel < 25) add_byte(pick("abcXYZ 019.,!?"));
    else if (sel < 35) add_byte($urandom_range(1) ? mmf_pkg::ChSpace : mmf_pkg::ChTab);
    else if (sel < 45) begin
      add_byte("<");
      add_byte(pick("rRaAdDcCfFsSwWqz"));
      if ($urandom_range(1)) begin
        repeat ($urandom_range(2)) add_byte(pick("0123456789"));
        if ($urandom_range(3) != 0) add_byte(":");
      end
    end else if (sel < 52) add_byte(">");
    else if (sel < 58) add_byte("|");
    else if (sel < 66) begin
      add_byte("\\");
      add_byte(pick("knk^~<>|\\xq"));
    end else if (sel < 70) add_byte(pick("^~"));
    else if (sel < 80) begin
      lead = $urandom_range(8'hf4, 8'hc2);
      add_byte(lead);
      repeat (cont_count(lead)) begin
        if ($urandom_range(9) == 0) add_byte($urandom_range(255));
        else add_byte($urandom_range(8'hbf, 8'h80));
      end
    end else add_byte($urandom_range(255));
  endtask

  task automatic add_message(int len);
    for (int i = 0; i < len; i++) add_token();
    add_byte($urandom_range(255), 1'b1);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) predict_word({s_axis_tdata, s_axis_tlast});
      if (pending_words.size() > 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        {s_axis_tdata, s_axis_tlast} <= pending_words.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready and result check
  always @(posedge clk_i or negedge rst_ni) begin
    mmf_pkg::res_t got;
    mmf_pkg::res_t exp_r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.data = m_axis_tdata[7:0];
        got.err  = m_axis_tdata[9:8];
        got.fin  = m_axis_tlast;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word kind=%0d byte=%02h fin=%0b err=%0d", $time,
                   got.kind, got.data, got.fin, got.err);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r || m_axis_tdata[15:10] !== '0) begin
            $display("%0t: mismatch expected kind=%0d byte=%02h fin=%0b err=%0d,",
                     $time, exp_r.kind, exp_r.data, exp_r.fin, exp_r.err,
                     " actual kind=%0d byte=%02h fin=%0b err=%0d",
                     got.kind, got.data, got.fin, got.err);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else if (!stim_done || expected_results.size() > 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_message_markup_filter failed");
        $finish;
      end
    end
  end

  initial begin
    string ws;
    errors = 0;
    stim_done = 1'b0;
    hold_send = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 17;
    recv_idle_pct = 49;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    p_mode = PM_NORMAL;
    p_tag_cnt = 0;
    p_read_seen = 1'b0;
    p_utf_pend = 0;
    p_held_cnt = 0;
    p_brk = 1'b0;
    p_content = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: substitutions, escapes, tags, ruby, utf-8, breaks, overflows
    add_text("^a~\\k\\n\\^\\~\\<\\>\\|\\\\\\q");
    add_text("<rkan|yomi>x<R>");
    add_text("<d12:x<C:<f9y<S<W<A>>>z<q>|>");
    add_byte(8'hc3, 1'b0); add_byte(8'ha9, 1'b0);
    add_byte(8'he2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hac, 1'b0);
    add_byte(8'hf4, 1'b0); add_byte(8'h80, 1'b0); add_byte(8'hbf, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hc2, 1'b0); add_byte("A", 1'b0); add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0); add_byte(8'he0, 1'b1);
    add_text(" \t\\k  x\\k\\k\t\\k");
    add_text("<r<r<a<r<r<r<r<r<r<d5:<r|q");
    ws = "";
    repeat (34) ws = {ws, " "};
    add_text({ws, "y"});
    wait (pending_words.size() == 0);

    // pause the sender until everything has drained
    hold_send = 1'b1;
    wait (expected_results.size() == 0 && !s_axis_tvalid);
    repeat (20) @(posedge clk_i);
    hold_send = 1'b0;

    // random messages over three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 17 : 0;
      for (int m = 0; m < 8; m++) add_message($urandom_range(14, 2));
      if (ph == 1) add_text({ws, "\t\\k", ws, ws, "z"});
      wait (pending_words.size() == 0);
    end

    wait (!s_axis_tvalid);
    stim_done = 1'b1;
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_message_markup_filter passed");
    end else begin
      $display("tb_message_markup_filter failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/mmf_pkg.sv
design/mmf_front.sv
design/mmf_queue.sv
design/mmf_back.sv
design/message_markup_filter.sv
tb/tb_message_markup_filter.sv
